// File: src/adrc_pkg.sv
// Shared types, codes and saturating arithmetic helpers for the ADRC attitude controller.
// Used by adrc_mul, adrc_attitude_controller, adrc_checker and the testbench. No dependencies.
package adrc_pkg;

   typedef struct packed {
      logic signed [31:0] rate_meas;
      logic signed [31:0] angle_target;
      logic signed [31:0] angle_meas;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic               clamped;
      logic signed [31:0] rate_estimate;
      logic signed [31:0] accel_estimate;
      logic signed [31:0] disturbance_estimate;
   } rsp_type;

   // Post-shift applied to a full product before saturation to 64 bits.
   typedef enum logic [2:0] {
      SHIFT_NONE,
      SHIFT_STATE,
      SHIFT_DATA,
      SHIFT_WORD,
      SHIFT_MIX
   } shift_type;

   localparam logic signed [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] SAT_MIN = {1'b1, {63{1'b0}}};
   localparam logic signed [63:0] GAIN_THREE = 64'sd3;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? SAT_MIN : SAT_MAX;
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? SAT_MIN : SAT_MAX;
      end
      return s[63:0];
   endfunction

endpackage

// File: src/adrc_mul.sv
// Bit-serial 64x64 signed multiplier with a post-shift selected per operation and 64-bit saturation.
// Depends on adrc_pkg (shift_type, SAT_MAX, SAT_MIN).
module adrc_mul import adrc_pkg::*; #(
   parameter int unsigned STATE_FRAC_BITS = 32,
   parameter int unsigned DATA_FRAC_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] op_a,
   input  logic signed [63:0] op_b,
   input  shift_type          shift_sel,
   output logic               done,
   output logic signed [63:0] product
);

   localparam int unsigned MIX_R = (2 * DATA_FRAC_BITS >= STATE_FRAC_BITS) ?
                                   2 * DATA_FRAC_BITS - STATE_FRAC_BITS : 0;
   localparam int unsigned MIX_L = (STATE_FRAC_BITS > 2 * DATA_FRAC_BITS) ?
                                   STATE_FRAC_BITS - 2 * DATA_FRAC_BITS : 0;

   logic              busy_ff;
   logic              post_ff;
   logic              done_ff;
   logic [5:0]        count_ff;
   logic              neg_ff;
   shift_type         sel_ff;
   logic [63:0]       mcand_ff;
   logic [63:0]       hi_ff;
   logic [63:0]       lo_ff;
   logic signed [63:0] product_ff;

   logic [63:0]        mag_a;
   logic [63:0]        mag_b;
   logic [64:0]        sum;
   logic [127:0]       mag_p;
   logic signed [127:0] sgn_p;
   logic signed [127:0] shf_p;
   logic signed [63:0]  product_in;

   assign mag_a = op_a[63] ? (~op_a + 64'd1) : op_a;
   assign mag_b = op_b[63] ? (~op_b + 64'd1) : op_b;
   assign sum   = {1'b0, hi_ff} + {1'b0, (lo_ff[0] ? mcand_ff : 64'd0)};

   always_comb begin
      mag_p = {hi_ff, lo_ff};
      sgn_p = neg_ff ? -$signed(mag_p) : $signed(mag_p);
      case (sel_ff)
         SHIFT_STATE: shf_p = sgn_p >>> STATE_FRAC_BITS;
         SHIFT_DATA:  shf_p = sgn_p >>> DATA_FRAC_BITS;
         SHIFT_WORD:  shf_p = sgn_p >>> 32;
         SHIFT_MIX:   shf_p = (sgn_p >>> MIX_R) <<< MIX_L;
         default:     shf_p = sgn_p;
      endcase
      if ((&shf_p[127:63]) || !(|shf_p[127:63])) begin
         product_in = shf_p[63:0];
      end else begin
         product_in = shf_p[127] ? SAT_MIN : SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         post_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
            neg_ff   <= op_a[63] ^ op_b[63];
            sel_ff   <= shift_sel;
            mcand_ff <= mag_a;
            hi_ff    <= '0;
            lo_ff    <= mag_b;
         end else if (busy_ff) begin
            hi_ff    <= sum[64:1];
            lo_ff    <= {sum[0], lo_ff[63:1]};
            count_ff <= count_ff + 6'd1;
            if (&count_ff) begin
               busy_ff <= 1'b0;
               post_ff <= 1'b1;
            end
         end else if (post_ff) begin
            post_ff    <= 1'b0;
            done_ff    <= 1'b1;
            product_ff <= product_in;
         end
      end
   end

   assign done    = done_ff;
   assign product = product_ff;

endmodule

// File: src/adrc_attitude_controller.sv
// Top level of the linear ADRC attitude controller: sequencer, state and config registers.
// Depends on adrc_pkg and the bit-serial multiplier adrc_mul.
//
//   channel   ports                          direction  moves
//   request   req_valid/req_ready/req_data   in         rate, target angle, measured angle
//   response  rsp_valid/rsp_ready/rsp_data   out        drive, clamp flag, three estimates
//   csr       csr_we/csr_addr/csr_wdata      in         one register write per cycle
//
// One item takes 15 serial multiplications on the single bit-serial multiplier, which forms
// one partial product per cycle.
// Reset is synchronous and active high; it restores register defaults and zeroes state.
// A new request transfer is taken while a finished response still waits in the output
// register; the sequencer only stalls when it finishes a second item before the first
// response transfer has happened.
module adrc_attitude_controller import adrc_pkg::*; #(
   parameter int unsigned DATA_FRAC_BITS  = 16,
   parameter int unsigned STATE_FRAC_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [3:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned SD_SHIFT = STATE_FRAC_BITS - DATA_FRAC_BITS;

   // Register indexes.
   localparam logic [3:0] REG_PERIOD = 4'd0;
   localparam logic [3:0] REG_BW     = 4'd1;
   localparam logic [3:0] REG_BGAIN  = 4'd2;
   localparam logic [3:0] REG_BINV   = 4'd3;
   localparam logic [3:0] REG_KPO    = 4'd4;
   localparam logic [3:0] REG_KPI    = 4'd5;
   localparam logic [3:0] REG_KDI    = 4'd6;
   localparam logic [3:0] REG_LIMIT  = 4'd7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_DONE
   } state_type;

   // One entry for each multiplication, in the order the control law needs them.
   typedef enum logic [3:0] {
      STEP_K1,
      STEP_WO2,
      STEP_K2,
      STEP_K3,
      STEP_RATE_IN,
      STEP_RATE_UPD,
      STEP_ACC_DRV,
      STEP_ACC_IN,
      STEP_ACC_UPD,
      STEP_DIST_IN,
      STEP_DIST_UPD,
      STEP_OUTER,
      STEP_INNER_P,
      STEP_INNER_D,
      STEP_CANCEL
   } step_type;

   function automatic logic signed [63:0] to_state(input logic signed [31:0] x);
      logic signed [63:0] w;
      w = {{32{x[31]}}, x};
      return w <<< SD_SHIFT;
   endfunction

   function automatic logic signed [31:0] from_state(input logic signed [63:0] x);
      logic signed [63:0] r;
      r = x >>> SD_SHIFT;
      if ((&r[63:31]) || !(|r[63:31])) begin
         return r[31:0];
      end
      return r[63] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
   endfunction

   // Configuration registers.
   logic [31:0]        period_ff;
   logic [30:0]        bw_ff;
   logic signed [31:0] bgain_ff;
   logic signed [31:0] binv_ff;
   logic signed [31:0] kpo_ff;
   logic signed [31:0] kpi_ff;
   logic signed [31:0] kdi_ff;
   logic [30:0]        limit_ff;

   // Observer state and the drive from the last period.
   logic signed [63:0] rate_ff;
   logic signed [63:0] accel_ff;
   logic signed [63:0] dist_ff;
   logic signed [31:0] last_drive_ff;

   // Per-item working registers.
   state_type          state_ff;
   step_type           step_ff;
   logic signed [63:0] k1_ff;
   logic signed [63:0] k2_ff;
   logic signed [63:0] w_ff;     // wo^2, later the third observer gain
   logic signed [63:0] e_ff;     // observer error
   logic signed [63:0] diff_ff;  // target minus measured angle
   logic signed [63:0] t_ff;     // running intermediate
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               mul_start;
   logic               mul_done;
   logic signed [63:0] mul_a;
   logic signed [63:0] mul_b;
   logic signed [63:0] mul_p;
   shift_type          mul_shift;

   logic signed [63:0] wo_s;
   logic signed [63:0] ts_s;
   logic signed [63:0] lim_s;
   logic signed [63:0] drive_in;
   logic               clamped_in;

   assign wo_s  = 64'($unsigned(bw_ff)) <<< SD_SHIFT;
   assign ts_s  = {32'd0, period_ff};
   assign lim_s = 64'($unsigned(limit_ff)) <<< SD_SHIFT;

   // Operand selection for the current multiplication.
   always_comb begin
      mul_a     = t_ff;
      mul_b     = ts_s;
      mul_shift = SHIFT_WORD;
      case (step_ff)
         STEP_K1:       begin mul_a = wo_s; mul_b = GAIN_THREE; mul_shift = SHIFT_NONE; end
         STEP_WO2:      begin mul_a = wo_s; mul_b = wo_s; mul_shift = SHIFT_STATE; end
         STEP_K2:       begin mul_a = w_ff; mul_b = GAIN_THREE; mul_shift = SHIFT_NONE; end
         STEP_K3:       begin mul_a = w_ff; mul_b = wo_s; mul_shift = SHIFT_STATE; end
         STEP_RATE_IN:  begin mul_a = k1_ff; mul_b = e_ff; mul_shift = SHIFT_STATE; end
         STEP_ACC_DRV:  begin
            mul_a     = {{32{bgain_ff[31]}}, bgain_ff};
            mul_b     = {{32{last_drive_ff[31]}}, last_drive_ff};
            mul_shift = SHIFT_MIX;
         end
         STEP_ACC_IN:   begin mul_a = k2_ff; mul_b = e_ff; mul_shift = SHIFT_STATE; end
         STEP_DIST_IN:  begin mul_a = w_ff; mul_b = e_ff; mul_shift = SHIFT_STATE; end
         STEP_OUTER:    begin
            mul_a     = {{32{kpo_ff[31]}}, kpo_ff};
            mul_b     = diff_ff;
            mul_shift = SHIFT_MIX;
         end
         STEP_INNER_P:  begin
            mul_a     = {{32{kpi_ff[31]}}, kpi_ff};
            mul_b     = sat_sub(t_ff, rate_ff);
            mul_shift = SHIFT_DATA;
         end
         STEP_INNER_D:  begin
            mul_a     = {{32{kdi_ff[31]}}, kdi_ff};
            mul_b     = accel_ff;
            mul_shift = SHIFT_DATA;
         end
         STEP_CANCEL:   begin
            mul_a     = dist_ff;
            mul_b     = {{32{binv_ff[31]}}, binv_ff};
            mul_shift = SHIFT_DATA;
         end
         default:       begin mul_a = t_ff; mul_b = ts_s; mul_shift = SHIFT_WORD; end
      endcase
   end

   // Symmetric clamp of the raw drive held in t_ff.
   always_comb begin
      drive_in   = t_ff;
      clamped_in = 1'b0;
      if (t_ff > lim_s) begin
         drive_in   = lim_s;
         clamped_in = 1'b1;
      end else if (t_ff < -lim_s) begin
         drive_in   = -lim_s;
         clamped_in = 1'b1;
      end
   end

   assign mul_start = (state_ff == ST_ISSUE);

   adrc_mul #(
      .STATE_FRAC_BITS (STATE_FRAC_BITS),
      .DATA_FRAC_BITS  (DATA_FRAC_BITS)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_start),
      .op_a      (mul_a),
      .op_b      (mul_b),
      .shift_sel (mul_shift),
      .done      (mul_done),
      .product   (mul_p)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= 32'd21474836;
         bw_ff     <= 31'd6553600;
         bgain_ff  <= 32'sd65536;
         binv_ff   <= 32'sd65536;
         kpo_ff    <= '0;
         kpi_ff    <= '0;
         kdi_ff    <= '0;
         limit_ff  <= {31{1'b1}};
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_PERIOD: period_ff <= csr_wdata;
            REG_BW:     bw_ff     <= csr_wdata[30:0];
            REG_BGAIN:  bgain_ff  <= csr_wdata;
            REG_BINV:   binv_ff   <= csr_wdata;
            REG_KPO:    kpo_ff    <= csr_wdata;
            REG_KPI:    kpi_ff    <= csr_wdata;
            REG_KDI:    kdi_ff    <= csr_wdata;
            REG_LIMIT:  limit_ff  <= csr_wdata[30:0];
            default:    ;
         endcase
      end
   end

   // Sequencer, observer state and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= STEP_K1;
         rsp_valid_ff  <= 1'b0;
         rate_ff       <= '0;
         accel_ff      <= '0;
         dist_ff       <= '0;
         last_drive_ff <= '0;
      end else begin
         // In the done state the response register is reloaded below instead.
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  e_ff     <= sat_sub(to_state(req_data.rate_meas), rate_ff);
                  diff_ff  <= {{32{req_data.angle_target[31]}}, req_data.angle_target}
                              - {{32{req_data.angle_meas[31]}}, req_data.angle_meas};
                  step_ff  <= STEP_K1;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (mul_done) begin
                  case (step_ff)
                     STEP_K1:       k1_ff    <= mul_p;
                     STEP_WO2:      w_ff     <= mul_p;
                     STEP_K2:       k2_ff    <= mul_p;
                     STEP_K3:       w_ff     <= mul_p;
                     STEP_RATE_IN:  t_ff     <= sat_add(accel_ff, mul_p);
                     STEP_RATE_UPD: rate_ff  <= sat_add(rate_ff, mul_p);
                     STEP_ACC_DRV:  t_ff     <= sat_add(mul_p, dist_ff);
                     STEP_ACC_IN:   t_ff     <= sat_add(t_ff, mul_p);
                     STEP_ACC_UPD:  accel_ff <= sat_add(accel_ff, mul_p);
                     STEP_DIST_IN:  t_ff     <= mul_p;
                     STEP_DIST_UPD: dist_ff  <= sat_add(dist_ff, mul_p);
                     STEP_OUTER:    t_ff     <= mul_p;
                     STEP_INNER_P:  t_ff     <= mul_p;
                     STEP_INNER_D:  t_ff     <= sat_sub(t_ff, mul_p);
                     STEP_CANCEL:   t_ff     <= sat_sub(t_ff, mul_p);
                     default:       t_ff     <= mul_p;
                  endcase
                  if (step_ff == STEP_CANCEL) begin
                     state_ff <= ST_DONE;
                  end else begin
                     step_ff  <= step_type'(4'(step_ff) + 4'd1);
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  last_drive_ff                <= from_state(drive_in);
                  rsp_ff.drive                 <= from_state(drive_in);
                  rsp_ff.clamped               <= clamped_in;
                  rsp_ff.rate_estimate         <= from_state(rate_ff);
                  rsp_ff.accel_estimate        <= from_state(accel_ff);
                  rsp_ff.disturbance_estimate  <= from_state(dist_ff);
                  rsp_valid_ff                 <= 1'b1;
                  state_ff                     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: src/adrc_checker.sv
// Port-level checker for the ADRC attitude controller, attached by bind.
// Depends on adrc_pkg and on the top level adrc_attitude_controller.
module adrc_checker import adrc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic [1:0] pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed before its transfer");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item was in progress");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without an outstanding request");

endmodule

bind adrc_attitude_controller adrc_checker u_adrc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: tb/adrc_attitude_controller_tb.sv
// Self-checking testbench for adrc_attitude_controller: drives control periods over the
// request channel, predicts each response with a fixed-point model, and checks every field.
// Depends on adrc_pkg (request and response types) and the controller RTL only.
`timescale 1ns / 1ps

module adrc_attitude_controller_tb;
   import adrc_pkg::*;

   // Register indexes of the CSR port.
   localparam logic [3:0] REG_SAMPLE_PERIOD = 4'd0;
   localparam logic [3:0] REG_OBS_BANDWIDTH = 4'd1;
   localparam logic [3:0] REG_PLANT_GAIN    = 4'd2;
   localparam logic [3:0] REG_PLANT_INVERSE = 4'd3;
   localparam logic [3:0] REG_OUTER_GAIN    = 4'd4;
   localparam logic [3:0] REG_INNER_P_GAIN  = 4'd5;
   localparam logic [3:0] REG_INNER_D_GAIN  = 4'd6;
   localparam logic [3:0] REG_OUTPUT_LIMIT  = 4'd7;
   localparam int NUM_REGS = 8;

   localparam int DFRAC = 16;
   localparam int SFRAC = 32;
   // The watchdog limit covers one control period plus a long response hold-off.
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLDOFF_CYCLES = 4000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [3:0]  csr_addr;
   logic [31:0] csr_wdata;

   adrc_attitude_controller DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Shadow copy of the register file, kept at register width.
   logic [31:0]        cfg_ts;
   logic [30:0]        cfg_wo;
   logic signed [31:0] cfg_bgain;
   logic signed [31:0] cfg_binv;
   logic signed [31:0] cfg_kpo;
   logic signed [31:0] cfg_kpi;
   logic signed [31:0] cfg_kdi;
   logic [30:0]        cfg_limit;

   // Shadow copy of the observer state and the drive held from the previous period.
   logic signed [63:0] obs_rate;
   logic signed [63:0] obs_accel;
   logic signed [63:0] obs_dist;
   logic signed [31:0] prev_drive;

   rsp_type expected_rsp_q[$];
   int      mismatch_count;
   int      stall_count;
   bit      no_idle;
   bit      hold_rsp;

   // Exact product, shifted (right for positive sh, left for negative), saturated to 64 bits.
   function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
      if (v > $signed({64'd0, SAT_MAX})) return SAT_MAX;
      if (v < $signed({{64{1'b1}}, SAT_MIN})) return SAT_MIN;
      return v[63:0];
   endfunction

   function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                         input logic signed [63:0] b,
                                                         input int sh);
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic signed [127:0] p;
      logic signed [63:0]  r;
      wa = a;
      wb = b;
      p = wa * wb;
      if (sh > 0) p = p >>> sh;
      r = sat64(p);
      if (sh < 0) begin
         wa = r;
         r = sat64(wa <<< (-sh));
      end
      return r;
   endfunction

   function automatic logic signed [63:0] data_to_state(input logic signed [63:0] x);
      return scaled_product(x, 64'sd1, DFRAC - SFRAC);
   endfunction

   function automatic logic signed [31:0] state_to_data(input logic signed [63:0] x);
      logic signed [63:0] r;
      r = scaled_product(x, 64'sd1, SFRAC - DFRAC);
      if (r > 64'sd2147483647) return 32'sh7fffffff;
      if (r < -64'sd2147483648) return 32'sh80000000;
      return r[31:0];
   endfunction

   // One control period: observer update, outer angle loop, inner loop with cancellation.
   function automatic rsp_type control_period(input req_type item);
      logic signed [63:0] ts, wo_s, g1, wo2, g2, g3, err, n_rate, n_acc, n_dist;
      logic signed [63:0] rate_cmd, raw, lim, u;
      rsp_type r;
      ts   = {32'd0, cfg_ts};
      lim  = data_to_state({33'd0, cfg_limit});
      wo_s = data_to_state({33'd0, cfg_wo});
      g1   = scaled_product(wo_s, GAIN_THREE, 0);
      wo2  = scaled_product(wo_s, wo_s, SFRAC);
      g2   = scaled_product(wo2, GAIN_THREE, 0);
      g3   = scaled_product(wo2, wo_s, SFRAC);

      err    = sat_sub(data_to_state(64'(item.rate_meas)), obs_rate);
      n_rate = sat_add(obs_rate,
                  scaled_product(sat_add(obs_accel, scaled_product(g1, err, SFRAC)), ts, 32));
      n_acc  = sat_add(obs_accel, scaled_product(
                  sat_add(sat_add(scaled_product(64'(cfg_bgain), 64'(prev_drive),
                                                 2 * DFRAC - SFRAC), obs_dist),
                          scaled_product(g2, err, SFRAC)), ts, 32));
      n_dist = sat_add(obs_dist, scaled_product(scaled_product(g3, err, SFRAC), ts, 32));
      obs_rate  = n_rate;
      obs_accel = n_acc;
      obs_dist  = n_dist;

      // The angle error cannot overflow 64 bits, so it is not saturated.
      rate_cmd = scaled_product(64'(cfg_kpo),
                                64'(item.angle_target) - 64'(item.angle_meas),
                                2 * DFRAC - SFRAC);
      raw = sat_sub(sat_sub(scaled_product(64'(cfg_kpi), sat_sub(rate_cmd, obs_rate), DFRAC),
                            scaled_product(64'(cfg_kdi), obs_accel, DFRAC)),
                    scaled_product(obs_dist, 64'(cfg_binv), DFRAC));
      r.clamped = 1'b0;
      if (raw > lim) begin
         u = lim;
         r.clamped = 1'b1;
      end else if (raw < -lim) begin
         u = -lim;
         r.clamped = 1'b1;
      end else begin
         u = raw;
      end
      prev_drive = state_to_data(u);
      r.drive                = prev_drive;
      r.rate_estimate        = state_to_data(obs_rate);
      r.accel_estimate       = state_to_data(obs_accel);
      r.disturbance_estimate = state_to_data(obs_dist);
      return r;
   endfunction

   function automatic void shadow_write(input logic [3:0] idx, input logic [31:0] v);
      case (idx)
         REG_SAMPLE_PERIOD: cfg_ts    = v;
         REG_OBS_BANDWIDTH: cfg_wo    = v[30:0];
         REG_PLANT_GAIN:    cfg_bgain = v;
         REG_PLANT_INVERSE: cfg_binv  = v;
         REG_OUTER_GAIN:    cfg_kpo   = v;
         REG_INNER_P_GAIN:  cfg_kpi   = v;
         REG_INNER_D_GAIN:  cfg_kdi   = v;
         REG_OUTPUT_LIMIT:  cfg_limit = v[30:0];
         default: ;
      endcase
   endfunction

   // Waits until every expected response has arrived, so registers may be rewritten.
   task automatic wait_idle();
      while (expected_rsp_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // Writes all eight registers in consecutive cycles; the enable is lowered once at the end.
   task automatic load_config(input logic [31:0] v [NUM_REGS]);
      wait_idle();
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= 4'(i);
         csr_wdata <= v[i];
         shadow_write(4'(i), v[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Offers one item and returns at the falling edge after its transfer.
   task automatic send_item(input req_type item);
      if (!no_idle && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsp_q.push_back(control_period(item));
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] moderate_value();
      return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
   endfunction

   function automatic req_type random_item(input bit full_range);
      req_type it;
      if (full_range) begin
         it.rate_meas    = $urandom;
         it.angle_target = $urandom;
         it.angle_meas   = $urandom;
      end else begin
         it.rate_meas    = moderate_value();
         it.angle_target = moderate_value();
         it.angle_meas   = moderate_value();
      end
      return it;
   endfunction

   // Responses are checked in order as each transfer completes.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: response transfer with none expected: %p", rsp_data);
         end else begin
            rsp_type exp_rsp;
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp_data.drive !== exp_rsp.drive
                || rsp_data.clamped !== exp_rsp.clamped
                || rsp_data.rate_estimate !== exp_rsp.rate_estimate
                || rsp_data.accel_estimate !== exp_rsp.accel_estimate
                || rsp_data.disturbance_estimate !== exp_rsp.disturbance_estimate) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: response mismatch\n  expected %p\n  actual   %p",
                           exp_rsp, rsp_data);
            end
         end
      end
   end

   // The receiver drops ready now and then, except during a quiet stretch or a hold-off.
   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_ready <= 1'b0;
      else if (no_idle) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 99) >= 8);
   end

   // Watchdog: any transfer on either channel, or an idle testbench, restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (!req_valid && expected_rsp_q.size() == 0)) begin
         stall_count <= 0;
      end else if (stall_count >= WATCHDOG_LIMIT) begin
         $display("adrc_attitude_controller test failed");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   task automatic hold_responses(input int cycles);
      hold_rsp = 1'b1;
      repeat (cycles) @(posedge clock);
      hold_rsp = 1'b0;
   endtask

   // With the reset gains the drive is only the cancellation term while the observer follows the rate.
   task automatic test_reset_defaults();
      req_type it;
      it = '{rate_meas: 32'sh7fffffff, angle_target: 32'sh80000000, angle_meas: 32'sh7fffffff};
      send_item(it);
      it = '{rate_meas: 32'sh80000000, angle_target: 32'sh7fffffff, angle_meas: 32'sh80000000};
      send_item(it);
      it = '{rate_meas: 32'sh0, angle_target: 32'sh0, angle_meas: 32'sh0};
      send_item(it);
      send_item(random_item(1'b0));
      stop_sending();
   endtask

   // Every register at its top and at its bottom value, over two settings.
   task automatic test_config_extremes();
      logic [31:0] v [NUM_REGS];
      v = '{32'hffffffff, 32'hffffffff, 32'h7fffffff, 32'h80000000,
            32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffffffff};
      load_config(v);
      repeat (3) send_item(random_item(1'b1));
      stop_sending();
      v = '{32'h0, 32'h0, 32'h80000000, 32'h7fffffff,
            32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000};
      load_config(v);
      repeat (2) send_item(random_item(1'b1));
      stop_sending();
   endtask

   // A zero limit forces the drive to zero and flags any nonzero raw drive.
   task automatic test_zero_limit();
      logic [31:0] v [NUM_REGS];
      req_type it;
      v = '{32'd21474836, 32'd6553600, 32'h10000, 32'h10000,
            32'h20000, 32'h30000, 32'h8000, 32'h0};
      load_config(v);
      it = '{rate_meas: 32'sh0, angle_target: 32'sh0, angle_meas: 32'sh0};
      send_item(it);
      it = '{rate_meas: 32'sh10000, angle_target: 32'sh50000, angle_meas: 32'shfffe0000};
      send_item(it);
      send_item(random_item(1'b0));
      stop_sending();
   endtask

   // The cancellation term uses the written inverse even when it does not match the
   // plant gain; writes to indexes past the register file must change nothing.
   task automatic test_mismatched_inverse();
      logic [31:0] v [NUM_REGS];
      v = '{32'd42949672, 32'd13107200, 32'h20000, 32'hfffd0000,
            32'h18000, 32'h28000, 32'h4000, 32'h00640000};
      load_config(v);
      for (int idx = NUM_REGS; idx < 16; idx++) begin
         csr_we    <= 1'b1;
         csr_addr  <= 4'(idx);
         csr_wdata <= $urandom;
         @(negedge clock);
      end
      csr_we <= 1'b0;
      repeat (4) send_item(random_item(1'b0));
      stop_sending();
   endtask

   // The receiver stalls long enough for the block to fill and refuse requests.
   task automatic test_backpressure();
      fork
         hold_responses(HOLDOFF_CYCLES);
      join_none
      repeat (6) send_item(random_item(1'b0));
      stop_sending();
   endtask

   task automatic randomize_config(input bit extreme);
      logic [31:0] v [NUM_REGS];
      if (extreme) begin
         foreach (v[i]) v[i] = $urandom;
      end else begin
         v[REG_SAMPLE_PERIOD] = $urandom_range(0, 32'h0800_0000);
         v[REG_OBS_BANDWIDTH] = $urandom_range(0, 32'h0200_0000) | ($urandom & 32'h8000_0000);
         for (int i = REG_PLANT_GAIN; i <= REG_INNER_D_GAIN; i++)
            v[i] = 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
         v[REG_OUTPUT_LIMIT] = ($urandom_range(0, 3) == 0) ? 32'h7fffffff
                                                           : $urandom_range(0, 32'h0100_0000);
      end
      load_config(v);
   endtask

   // Random periods over several register settings, mostly in a usable range.
   task automatic test_random_periods();
      for (int phase = 0; phase < 6; phase++) begin
         randomize_config(phase == 5);
         no_idle = (phase == 2);
         for (int n = 0; n < 160; n++)
            send_item(random_item($urandom_range(0, 9) == 0));
         stop_sending();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_we         = 1'b0;
      csr_addr       = '0;
      csr_wdata      = '0;
      hold_rsp       = 1'b0;
      no_idle        = 1'b0;
      cfg_ts = 32'd21474836;
      cfg_wo = 31'd6553600;
      cfg_bgain = 32'sh10000;
      cfg_binv  = 32'sh10000;
      cfg_kpo = '0;
      cfg_kpi = '0;
      cfg_kdi = '0;
      cfg_limit = 31'h7fffffff;
      obs_rate = '0;
      obs_accel = '0;
      obs_dist = '0;
      prev_drive = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_config_extremes();
      test_zero_limit();
      test_mismatched_inverse();
      test_backpressure();
      test_random_periods();

      wait_idle();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("adrc_attitude_controller test passed");
      end else begin
         $display("adrc_attitude_controller test failed");
      end
      $finish;
   end

endmodule

// File: sim.f
src/adrc_pkg.sv
src/adrc_mul.sv
src/adrc_attitude_controller.sv
src/adrc_checker.sv
tb/adrc_attitude_controller_tb.sv
